// ===== rtl/swl_pkg.sv =====
// ----------------------------------------------------------------------------
// swl_pkg
// Types, character codes and the per-character step function of the lexer.
// ----------------------------------------------------------------------------
package swl_pkg;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_QUOTE = 2'd2,
		MODE_QESC  = 2'd3
	} lexer_mode_t;

	localparam logic [1:0] KIND_CHAR     = 2'd0;
	localparam logic [1:0] KIND_WORD_END = 2'd1;
	localparam logic [1:0] KIND_DONE     = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		lexer_mode_t mode;
		logic        word_nonempty;
		logic        discarding;
	} lex_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] word_char;
		logic       last_of_run;
	} lex_result_t;

	typedef struct packed {
		lex_state_t                     nxt;
		logic [1:0]                     n;
		lex_result_t [MAX_RES-1:0]      res;
	} lex_step_t;

	function automatic logic plain_esc_ok(logic [7:0] c);
		logic ok;
		case (c) inside
			CH_SPACE, CH_SQUOTE, CH_LT, CH_GT, CH_TILDE, CH_PIPE, CH_AMP, CH_SEMI,
			CH_STAR, CH_QMARK, CH_HASH, CH_LPAREN, CH_RPAREN, CH_DQUOTE, CH_BTICK,
			CH_BSLASH, CH_DOLLAR, CH_LOW_N, CH_LOW_T: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic quote_esc_ok(logic [7:0] c);
		logic ok;
		case (c) inside
			CH_DQUOTE, CH_BTICK, CH_BSLASH, CH_DOLLAR: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic lex_step_t lex_step(lex_state_t st, logic [7:0] c, logic has,
			logic eol);
		lex_step_t  r;
		lex_state_t s;
		logic       err;
		logic [1:0] n;
		logic [7:0] v;
		r   = '0;
		s   = st;
		err = 1'b0;
		n   = 2'd0;
		v   = c;
		if (st.discarding) begin
			if (eol) begin
				s = '0;
			end
		end else begin
			if (has) begin
				unique case (st.mode)
					MODE_PLAIN: begin
						if (c == CH_BSLASH) begin
							s.mode = MODE_ESC;
						end else if (c == CH_DQUOTE) begin
							s.mode = MODE_QUOTE;
						end else if (c == CH_SPACE) begin
							r.res[n] = '{KIND_WORD_END, 8'd0, 1'b0};
							n = n + 2'd1;
							s.word_nonempty = 1'b0;
						end else begin
							r.res[n] = '{KIND_CHAR, c, 1'b0};
							n = n + 2'd1;
							s.word_nonempty = 1'b1;
						end
					end
					MODE_ESC: begin
						if (plain_esc_ok(c)) begin
							if (c == CH_LOW_N) begin
								v = CH_NL;
							end else if (c == CH_LOW_T) begin
								v = CH_TAB;
							end
							r.res[n] = '{KIND_CHAR, v, 1'b0};
							n = n + 2'd1;
							s.word_nonempty = 1'b1;
							s.mode = MODE_PLAIN;
						end else begin
							err = 1'b1;
						end
					end
					MODE_QUOTE: begin
						if (c == CH_DQUOTE) begin
							s.mode = MODE_PLAIN;
						end else if (c == CH_BSLASH) begin
							s.mode = MODE_QESC;
						end else begin
							r.res[n] = '{KIND_CHAR, c, 1'b0};
							n = n + 2'd1;
							s.word_nonempty = 1'b1;
						end
					end
					MODE_QESC: begin
						if (quote_esc_ok(c)) begin
							r.res[n] = '{KIND_CHAR, c, 1'b0};
							n = n + 2'd1;
							s.word_nonempty = 1'b1;
							s.mode = MODE_QUOTE;
						end else begin
							err = 1'b1;
						end
					end
					default: err = 1'b1;
				endcase
			end
			if (!err && eol && s.mode != MODE_PLAIN) begin
				err = 1'b1;
			end
			if (err) begin
				r.res[n] = '{KIND_ERROR, 8'd0, 1'b0};
				n = n + 2'd1;
				s = '0;
				s.discarding = !eol;
			end else if (eol) begin
				if (s.word_nonempty) begin
					r.res[n] = '{KIND_WORD_END, 8'd0, 1'b0};
					n = n + 2'd1;
				end
				r.res[n] = '{KIND_DONE, 8'd0, 1'b0};
				n = n + 2'd1;
				s = '0;
			end
			if (n != 2'd0) begin
				r.res[n - 2'd1].last_of_run = 1'b1;
			end
		end
		r.nxt = s;
		r.n   = n;
		return r;
	endfunction

endpackage

// ===== rtl/swl_if.sv =====
// ----------------------------------------------------------------------------
// swl_if
// Valid/ready channels for characters in and lexer results out.
// ----------------------------------------------------------------------------
interface swl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       has_character;
	logic       end_of_line;

	modport source (output valid, character, has_character, end_of_line, input ready);
	modport sink (input valid, character, has_character, end_of_line, output ready);
endinterface

interface swl_tok_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] word_char;
	logic       last_of_run;

	modport source (output valid, kind, word_char, last_of_run, input ready);
	modport sink (input valid, kind, word_char, last_of_run, output ready);
endinterface

// ===== rtl/swl_res_fifo.sv =====
// ----------------------------------------------------------------------------
// swl_res_fifo
// Four-entry result queue taking up to three results per cycle, one out.
// ----------------------------------------------------------------------------
module swl_res_fifo
	import swl_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [1:0]                push_n,
	input  lex_result_t [MAX_RES-1:0] push_data,
	output logic [2:0]                free,
	output logic                      valid,
	output lex_result_t               head,
	input  logic                      pop
);

	lex_result_t mem_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	assign free  = 3'd4 - count_q;
	assign valid = count_q != 3'd0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push_n) begin
				mem_q[wr_ptr_q + 2'(i)] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push_n} - {2'b0, pop};
		end
	end

endmodule

// ===== rtl/shell_word_lexer.sv =====
// ----------------------------------------------------------------------------
// shell_word_lexer
// Splits a command line into words, one character beat per cycle unless stalled.
// ----------------------------------------------------------------------------
// An accepted beat is registered in the s1 stage, then its results are queued.
// Throughput: one character beat per cycle while each causes at most one result
// and the four-entry result queue has room; results leave at one per ready cycle.
// Reset: asynchronous, clears the mode, the word and discard flags and the queue.
// ----------------------------------------------------------------------------
module shell_word_lexer
	import swl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	swl_char_if.sink     char_ch,
	swl_tok_if.source    tok_ch
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        has_s1;
	logic        eol_s1;
	lex_state_t  state_q;
	lex_step_t   step;
	logic [2:0]  free;
	logic        fire;
	logic        fifo_valid;
	lex_result_t head;

	assign step          = lex_step(state_q, char_s1, has_s1, eol_s1);
	assign fire          = valid_s1 && (free >= {1'b0, step.n});
	assign char_ch.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (char_ch.ready) begin
				valid_s1 <= char_ch.valid;
			end
			if (fire) begin
				state_q <= step.nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.ready && char_ch.valid) begin
			char_s1 <= char_ch.character;
			has_s1  <= char_ch.has_character;
			eol_s1  <= char_ch.end_of_line;
		end
	end

	swl_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire ? step.n : 2'd0),
		.push_data (step.res),
		.free      (free),
		.valid     (fifo_valid),
		.head      (head),
		.pop       (fifo_valid && tok_ch.ready)
	);

	assign tok_ch.valid       = fifo_valid;
	assign tok_ch.kind        = head.kind;
	assign tok_ch.word_char   = head.word_char;
	assign tok_ch.last_of_run = head.last_of_run;

	a_eol_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eol_s1 |=> state_q == '0)
		else $error("state not cleared after end of line");

	a_discard_plain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.discarding |-> state_q.mode == MODE_PLAIN && !state_q.word_nonempty)
		else $error("discarding with live word state");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_ch.valid && (tok_ch.kind == KIND_DONE || tok_ch.kind == KIND_ERROR)
		|-> tok_ch.last_of_run)
		else $error("line marker not last of run");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(char_s1) && $stable(eol_s1))
		else $error("stalled input register changed");

endmodule

// ===== dv/shell_word_lexer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_word_lexer_checker
// Watches the character and result channels of the lexer. It keeps its own
// model of the lexer's mode, word and discard flags, and works out the
// result beats that each accepted character beat should cause. It compares
// every accepted result beat, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module shell_word_lexer_checker
	import swl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	swl_char_if  char_mon,
	swl_tok_if   tok_mon,
	output int   fail_count,
	output int   pending,
	output int   results_checked,
	output int   lines_rejected
);

	localparam logic [7:0] SHELL_META [17] = '{
		CH_SPACE, CH_SQUOTE, CH_LT, CH_GT, CH_TILDE, CH_PIPE, CH_AMP, CH_SEMI, CH_STAR,
		CH_QMARK, CH_HASH, CH_LPAREN, CH_RPAREN, CH_DQUOTE, CH_BTICK, CH_BSLASH, CH_DOLLAR
	};
	localparam logic [7:0] QUOTED_META [4] = '{CH_DQUOTE, CH_BTICK, CH_BSLASH, CH_DOLLAR};

	lexer_mode_t mode_q;
	logic        word_open;
	logic        skip_line;
	lex_result_t expected_tokens[$];

	function automatic logic is_shell_meta(logic [7:0] c);
		logic hit;
		hit = 1'b0;
		foreach (SHELL_META[i]) begin
			if (SHELL_META[i] == c) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic logic is_quoted_meta(logic [7:0] c);
		logic hit;
		hit = 1'b0;
		foreach (QUOTED_META[i]) begin
			if (QUOTED_META[i] == c) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	task automatic owe_token(logic [1:0] kind, logic [7:0] ch);
		lex_result_t t;
		t.kind        = kind;
		t.word_char   = ch;
		t.last_of_run = 1'b0;
		expected_tokens.insert(expected_tokens.size(), t);
	endtask

	task automatic predict_tokens(logic [7:0] c, logic has, logic eol);
		int   owed_before;
		logic bad;
		owed_before = expected_tokens.size();
		bad         = 1'b0;
		if (skip_line) begin
			if (eol) begin
				skip_line = 1'b0;
			end
			return;
		end
		if (has) begin
			case (mode_q)
				MODE_PLAIN: begin
					if (c == CH_BSLASH) begin
						mode_q = MODE_ESC;
					end else if (c == CH_DQUOTE) begin
						mode_q = MODE_QUOTE;
					end else if (c == CH_SPACE) begin
						owe_token(KIND_WORD_END, 8'd0);
						word_open = 1'b0;
					end else begin
						owe_token(KIND_CHAR, c);
						word_open = 1'b1;
					end
				end
				MODE_ESC: begin
					if (c == CH_LOW_N || c == CH_LOW_T || is_shell_meta(c)) begin
						owe_token(KIND_CHAR, (c == CH_LOW_N) ? CH_NL : (c == CH_LOW_T) ? CH_TAB : c);
						word_open = 1'b1;
						mode_q    = MODE_PLAIN;
					end else begin
						bad = 1'b1;
					end
				end
				MODE_QUOTE: begin
					if (c == CH_DQUOTE) begin
						mode_q = MODE_PLAIN;
					end else if (c == CH_BSLASH) begin
						mode_q = MODE_QESC;
					end else begin
						owe_token(KIND_CHAR, c);
						word_open = 1'b1;
					end
				end
				default: begin
					if (is_quoted_meta(c)) begin
						owe_token(KIND_CHAR, c);
						word_open = 1'b1;
						mode_q    = MODE_QUOTE;
					end else begin
						bad = 1'b1;
					end
				end
			endcase
		end
		if (!bad && eol && mode_q != MODE_PLAIN) begin
			bad = 1'b1;
		end
		if (bad) begin
			owe_token(KIND_ERROR, 8'd0);
			lines_rejected++;
			mode_q    = MODE_PLAIN;
			word_open = 1'b0;
			skip_line = !eol;
		end else if (eol) begin
			if (word_open) begin
				owe_token(KIND_WORD_END, 8'd0);
			end
			owe_token(KIND_DONE, 8'd0);
			mode_q    = MODE_PLAIN;
			word_open = 1'b0;
		end
		if (expected_tokens.size() > owed_before) begin
			expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
		end
	endtask

	task automatic check_token();
		lex_result_t want;
		if (expected_tokens.size() == 0) begin
			$error("Result beat with nothing owed: kind %0d, word_char 0x%02h, last_of_run %0b",
				tok_mon.kind, tok_mon.word_char, tok_mon.last_of_run);
			fail_count++;
			return;
		end
		want = expected_tokens.pop_front();
		results_checked++;
		if (tok_mon.kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, tok_mon.kind);
			fail_count++;
		end
		if (tok_mon.word_char !== want.word_char) begin
			$error("word_char: expected 0x%02h, got 0x%02h", want.word_char, tok_mon.word_char);
			fail_count++;
		end
		if (tok_mon.last_of_run !== want.last_of_run) begin
			$error("last_of_run: expected %0b, got %0b", want.last_of_run, tok_mon.last_of_run);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    = MODE_PLAIN;
			word_open = 1'b0;
			skip_line = 1'b0;
			expected_tokens.delete();
			fail_count      = 0;
			pending         = 0;
			results_checked = 0;
			lines_rejected  = 0;
		end else begin
			if (char_mon.valid && char_mon.ready) begin
				predict_tokens(char_mon.character, char_mon.has_character, char_mon.end_of_line);
			end
			if (tok_mon.valid && tok_mon.ready) begin
				check_token();
			end
			pending = expected_tokens.size();
		end
	end

endmodule

// ===== dv/shell_word_lexer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_word_lexer_tb
// Drives command lines into the lexer: a directed set of lines for the
// escapes, quotes, empty words and several kinds of line error, then random
// lines, mostly well formed with a share of broken ones. Both channels idle
// at random. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module shell_word_lexer_tb;
	import swl_pkg::*;

	localparam int RANDOM_BEATS = 420;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 8;

	localparam logic [7:0] ESCAPABLE [19] = '{
		CH_LOW_N, CH_LOW_T, CH_SPACE, CH_SQUOTE, CH_LT, CH_GT, CH_TILDE, CH_PIPE, CH_AMP,
		CH_SEMI, CH_STAR, CH_QMARK, CH_HASH, CH_LPAREN, CH_RPAREN, CH_DQUOTE, CH_BTICK,
		CH_BSLASH, CH_DOLLAR
	};
	localparam logic [7:0] QUOTE_ESCAPABLE [4] = '{CH_DQUOTE, CH_BTICK, CH_BSLASH, CH_DOLLAR};

	logic clk;
	logic arst_n;
	bit   calm;
	int   cycles;
	int   beats_sent;
	int   lines_sent;
	int   fail_count;
	int   pending;
	int   results_checked;
	int   lines_rejected;

	swl_char_if char_ch();
	swl_tok_if  tok_ch();

	shell_word_lexer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.tok_ch  (tok_ch)
	);

	shell_word_lexer_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_mon        (char_ch),
		.tok_mon         (tok_ch),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.lines_rejected  (lines_rejected)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 24);
	endfunction

	initial begin
		int gap;
		tok_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				tok_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tok_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	task automatic send_beat(logic [7:0] c, logic has, logic eol);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			char_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_ch.valid         <= 1'b1;
		char_ch.character     <= c;
		char_ch.has_character <= has;
		char_ch.end_of_line   <= eol;
		do @(posedge clk); while (!char_ch.ready);
		if (has || eol) begin
			beats_sent++;
		end
		if (eol) begin
			lines_sent++;
		end
	endtask

	// Holds the sender back until every owed result beat has been taken.
	task automatic drain();
		char_ch.valid <= 1'b0;
		do begin
			while (pending != 0) @(posedge clk);
			repeat (SETTLE) @(posedge clk);
		end while (pending != 0);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do c = 8'($urandom); while (c == CH_BSLASH || c == CH_DQUOTE);
		return c;
	endfunction

	task automatic send_line(bit well_formed);
		logic [7:0] line_q[$];
		int         n_parts;
		int         n_inner;
		int         pos;
		bit         eol_on_last;
		n_parts = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
		repeat (n_parts) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: line_q.insert(line_q.size(), plain_byte());
				4: line_q.insert(line_q.size(), CH_SPACE);
				5, 6: begin
					line_q.insert(line_q.size(), CH_BSLASH);
					line_q.insert(line_q.size(), ESCAPABLE[$urandom_range(0, 18)]);
				end
				default: begin
					line_q.insert(line_q.size(), CH_DQUOTE);
					n_inner = $urandom_range(0, 4);
					repeat (n_inner) begin
						if ($urandom_range(0, 4) == 0) begin
							line_q.insert(line_q.size(), CH_BSLASH);
							line_q.insert(line_q.size(), QUOTE_ESCAPABLE[$urandom_range(0, 3)]);
						end else begin
							line_q.insert(line_q.size(), plain_byte());
						end
					end
					line_q.insert(line_q.size(), CH_DQUOTE);
				end
			endcase
		end
		if (!well_formed) begin
			case ($urandom_range(0, 3))
				0: repeat ($urandom_range(1, 4)) line_q.insert(line_q.size(), 8'($urandom));
				1: line_q.insert(line_q.size(), CH_BSLASH);
				2: begin
					line_q.insert(line_q.size(), CH_DQUOTE);
					line_q.insert(line_q.size(), 8'($urandom));
				end
				default: begin
					pos = $urandom_range(0, line_q.size());
					line_q.insert(pos, 8'($urandom));
					line_q.insert(pos, CH_BSLASH);
				end
			endcase
		end
		eol_on_last = (line_q.size() != 0) && ($urandom_range(0, 1) == 1);
		foreach (line_q[i]) begin
			if ($urandom_range(0, 19) == 0) begin
				send_beat(8'($urandom), 1'b0, 1'b0);
			end
			send_beat(line_q[i], 1'b1, eol_on_last && (i == line_q.size() - 1));
		end
		if (!eol_on_last) begin
			send_beat(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	initial begin
		int stop_at;
		arst_n                = 1'b0;
		calm                  = 1'b0;
		beats_sent            = 0;
		lines_sent            = 0;
		char_ch.valid         <= 1'b0;
		char_ch.character     <= 8'd0;
		char_ch.has_character <= 1'b0;
		char_ch.end_of_line   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Words, an empty word, plain escapes and a quoted escape, then a
		// character that also ends the line.
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(CH_SPACE, 1'b1, 1'b0);
		send_beat(CH_SPACE, 1'b1, 1'b0);
		send_beat(CH_BSLASH, 1'b1, 1'b0);
		send_beat(CH_LOW_N, 1'b1, 1'b0);
		send_beat(CH_BSLASH, 1'b1, 1'b0);
		send_beat(CH_LOW_T, 1'b1, 1'b0);
		send_beat(CH_DQUOTE, 1'b1, 1'b0);
		send_beat(CH_BSLASH, 1'b1, 1'b0);
		send_beat(CH_DQUOTE, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(CH_DQUOTE, 1'b1, 1'b0);
		send_beat(8'h7A, 1'b1, 1'b1);
		// An empty pair of quotes leaves the word empty at the end of the line.
		send_beat(CH_DQUOTE, 1'b1, 1'b0);
		send_beat(CH_DQUOTE, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		// A bad escape mid-line; the rest of the line is thrown away.
		send_beat(CH_BSLASH, 1'b1, 1'b0);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		// Lines that end inside a quote, on a bad escape, after a bad quoted escape, or inside an escape.
		send_beat(CH_DQUOTE, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(CH_BSLASH, 1'b1, 1'b0);
		send_beat(8'h71, 1'b1, 1'b1);
		send_beat(CH_DQUOTE, 1'b1, 1'b0);
		send_beat(CH_BSLASH, 1'b1, 1'b0);
		send_beat(CH_LOW_N, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_beat(CH_BSLASH, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b1);
		drain();

		stop_at = beats_sent + RANDOM_BEATS;
		while (beats_sent < stop_at) begin
			calm = ($urandom_range(0, 5) == 0);
			send_line($urandom_range(0, 99) < 85);
			if (lines_sent % 40 == 0) begin
				drain();
			end
		end
		calm = 1'b0;
		drain();

		$display("Sent %0d character beats in %0d lines; checked %0d result beats.",
			beats_sent, lines_sent, results_checked);
		$display("Lines rejected by the lexer: %0d.", lines_rejected);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/swl_pkg.sv
rtl/swl_if.sv
rtl/swl_res_fifo.sv
rtl/shell_word_lexer.sv
dv/shell_word_lexer_checker.sv
dv/shell_word_lexer_tb.sv
